[rtl/ppv_pkg.sv]
// ----------------------------------------------------------------------------
// ppv_pkg
// Shared types, widths, register codes and helpers for the perspective
// vertex projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppv_pkg;

  // Field widths
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SCALAR_W   = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned VEC_W      = 48;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 4;

  // Internal arithmetic widths
  localparam int unsigned DIFF_W = 17;  // world minus eye, Q9.8
  localparam int unsigned PROD_W = 33;  // diff times axis, Q.22
  localparam int unsigned DOT_W  = 35;  // sum of three products
  localparam int unsigned MAG_W  = 33;  // magnitude of a dot product
  localparam int unsigned NEAR_W = 30;  // near plane at Q.22
  localparam int unsigned QUO_W  = 17;  // quotient bits before saturation

  localparam int unsigned NUMX_W = 61;
  localparam int unsigned DENX_W = 65;
  localparam int unsigned NUMY_W = 53;
  localparam int unsigned DENY_W = 49;
  localparam int unsigned NUMD_W = 61;
  localparam int unsigned DEND_W = 49;

  // Divider pipeline depth: overflow check plus one stage per quotient bit
  localparam int unsigned DIV_LAT = QUO_W + 1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EYE   = 4'd0,
    REG_RIGHT = 4'd1,
    REG_UP    = 4'd2,
    REG_FWD   = 4'd3,
    REG_TAN   = 4'd4,
    REG_ASP   = 4'd5,
    REG_NEAR  = 4'd6,
    REG_FAR   = 4'd7
  } cfg_reg_e;

  // Reset values
  localparam logic [VEC_W-1:0]    EYE_RST   = 48'h0000_0000_0000;
  localparam logic [VEC_W-1:0]    RIGHT_RST = 48'h0000_0000_4000;
  localparam logic [VEC_W-1:0]    UP_RST    = 48'h0000_4000_0000;
  localparam logic [VEC_W-1:0]    FWD_RST   = 48'h4000_0000_0000;
  localparam logic [SCALAR_W-1:0] TAN_RST   = 16'd124;
  localparam logic [SCALAR_W-1:0] ASP_RST   = 16'd256;
  localparam logic [SCALAR_W-1:0] NEAR_RST  = 16'd51;
  localparam logic [SCALAR_W-1:0] FAR_RST   = 16'd5120;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } vtx_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] ndc_x;
    logic signed [OUT_W-1:0] ndc_y;
    logic signed [OUT_W-1:0] ndc_depth;
    logic                    depth_clamped;
    logic                    saturated;
    logic                    config_error;
  } res_t;

  typedef struct packed {
    logic [VEC_W-1:0]    eye;
    logic [VEC_W-1:0]    right;
    logic [VEC_W-1:0]    up;
    logic [VEC_W-1:0]    fwd;
    logic [SCALAR_W-1:0] tan_fov;
    logic [SCALAR_W-1:0] aspect;
    logic [SCALAR_W-1:0] near;
    logic [SCALAR_W-1:0] far;
  } cfg_t;

  // Per-item flags that ride beside the dividers
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic clamped;
    logic cfg_err;
  } side_t;

  // Front end to divider bank
  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [NUMX_W-1:0] num_x;
    logic [DENX_W-1:0] den_x;
    logic [NUMY_W-1:0] num_y;
    logic [DENY_W-1:0] den_y;
    logic [NUMD_W-1:0] num_d;
    logic [DEND_W-1:0] den_d;
  } front_t;

  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             sat;
  } sat_t;

  // Signed Q8.8/Q2.14 lane k of a packed vector
  function automatic logic signed [15:0] lane(input logic [VEC_W-1:0] v, input int unsigned k);
    lane = $signed(v[16*k +: 16]);
  endfunction

  // Sign and magnitude to 16-bit two's complement, saturating
  function automatic sat_t sat16(input logic neg, input logic ovf,
                                 input logic [QUO_W-1:0] mag);
    sat_t r;
    if (neg) begin
      if (ovf || mag > QUO_W'(32768)) begin
        r.code = 16'h8000;
        r.sat  = 1'b1;
      end else begin
        r.code = OUT_W'(QUO_W'(0) - mag);
        r.sat  = 1'b0;
      end
    end else if (ovf || mag > QUO_W'(32767)) begin
      r.code = 16'h7fff;
      r.sat  = 1'b1;
    end else begin
      r.code = mag[OUT_W-1:0];
      r.sat  = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ppv_if.sv]
// ----------------------------------------------------------------------------
// ppv_if
// Valid/ready channels for vertices in and projected results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppv_vtx_if;
  logic          valid;
  logic          ready;
  ppv_pkg::vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppv_res_if;
  logic          valid;
  logic          ready;
  ppv_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ppv_div.sv]
// ----------------------------------------------------------------------------
// ppv_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// check up front for quotients that do not fit QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ppv_div #(
  parameter int unsigned NW = 61,
  parameter int unsigned DW = 65,
  parameter int unsigned QW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o,
  output logic               ovf_o
);

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // Overflow check: quotient would need more than QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QW);
    end
  end

  // One compare and subtract per quotient bit, MSB first
  for (genvar j = 1; j <= QW; j++) begin : g_bit
    localparam int unsigned B = QW - j;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(den_q[j-1]) << B;
    assign ge    = CW'(rem_q[j-1]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_q[j-1][QW-2:0], ge};
        ovf_q[j] <= ovf_q[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? NW'(CW'(rem_q[j-1]) - trial) : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

`default_nettype wire

[rtl/ppv_front.sv]
// ----------------------------------------------------------------------------
// ppv_front
// View transform front end: eye subtract, axis products, dot sums, near
// clamp, and the multiplies that build the divider numerators and divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module ppv_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            in_valid_i,
  input  wire ppv_pkg::vtx_t   in_data_i,
  input  wire ppv_pkg::cfg_t   cfg_i,
  output ppv_pkg::front_t      out_o
);

  localparam int unsigned DIFF_W = ppv_pkg::DIFF_W;
  localparam int unsigned PROD_W = ppv_pkg::PROD_W;
  localparam int unsigned DOT_W  = ppv_pkg::DOT_W;
  localparam int unsigned MAG_W  = ppv_pkg::MAG_W;
  localparam int unsigned DENY_W = ppv_pkg::DENY_W;

  logic [4:0] vld_q;
  logic [4:0] err_q;

  logic signed [DIFF_W-1:0] diff_q [3];
  logic signed [PROD_W-1:0] pr_q [3];
  logic signed [PROD_W-1:0] pu_q [3];
  logic signed [PROD_W-1:0] pf_q [3];
  logic signed [DOT_W-1:0]  dr_q, du_q, dz_q;

  logic [MAG_W-1:0] dzc4_q, magr4_q, magu4_q, magr5_q, magu5_q;
  logic             negr4_q, negu4_q, clamp4_q;
  logic             negr5_q, negu5_q, clamp5_q;
  logic [DENY_W-1:0] deny5_q, numd5_q, dend5_q;

  logic [ppv_pkg::NEAR_W-1:0] near_q22;
  logic signed [DOT_W-1:0]    near_s;
  logic                       cfg_err;
  logic                       below_near;

  assign near_q22   = {cfg_i.near, 14'd0};
  assign near_s     = $signed(DOT_W'(near_q22));
  assign below_near = dz_q < near_s;
  assign cfg_err    = (cfg_i.far <= cfg_i.near) || (cfg_i.near == '0) ||
                      (cfg_i.tan_fov == '0) || (cfg_i.aspect == '0);

  // Valid and error flags travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      err_q <= {err_q[3:0], cfg_err};
    end
  end

  // Stage 1: world minus eye
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      diff_q[0] <= DIFF_W'(in_data_i.pos_x) - DIFF_W'(ppv_pkg::lane(cfg_i.eye, 0));
      diff_q[1] <= DIFF_W'(in_data_i.pos_y) - DIFF_W'(ppv_pkg::lane(cfg_i.eye, 1));
      diff_q[2] <= DIFF_W'(in_data_i.pos_z) - DIFF_W'(ppv_pkg::lane(cfg_i.eye, 2));
    end
  end

  // Stage 2: nine lane products
  for (genvar k = 0; k < 3; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        pr_q[k] <= diff_q[k] * ppv_pkg::lane(cfg_i.right, k);
        pu_q[k] <= diff_q[k] * ppv_pkg::lane(cfg_i.up, k);
        pf_q[k] <= diff_q[k] * ppv_pkg::lane(cfg_i.fwd, k);
      end
    end
  end

  // Stage 3: dot product sums
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dr_q <= DOT_W'(pr_q[0]) + DOT_W'(pr_q[1]) + DOT_W'(pr_q[2]);
      du_q <= DOT_W'(pu_q[0]) + DOT_W'(pu_q[1]) + DOT_W'(pu_q[2]);
      dz_q <= DOT_W'(pf_q[0]) + DOT_W'(pf_q[1]) + DOT_W'(pf_q[2]);
    end
  end

  // Stage 4: near clamp, sign and magnitude
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dzc4_q   <= below_near ? MAG_W'(near_q22) : MAG_W'(dz_q);
      clamp4_q <= below_near;
      negr4_q  <= dr_q[DOT_W-1];
      negu4_q  <= du_q[DOT_W-1];
      magr4_q  <= dr_q[DOT_W-1] ? MAG_W'(-dr_q) : MAG_W'(dr_q);
      magu4_q  <= du_q[DOT_W-1] ? MAG_W'(-du_q) : MAG_W'(du_q);
    end
  end

  // Stage 5: depth times tan, depth map numerator and divisor
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      deny5_q  <= DENY_W'(dzc4_q) * DENY_W'(cfg_i.tan_fov);
      numd5_q  <= DENY_W'(dzc4_q - MAG_W'(near_q22)) * DENY_W'(cfg_i.far);
      dend5_q  <= DENY_W'(dzc4_q) * DENY_W'(cfg_i.far - cfg_i.near);
      magr5_q  <= magr4_q;
      magu5_q  <= magu4_q;
      negr5_q  <= negr4_q;
      negu5_q  <= negu4_q;
      clamp5_q <= clamp4_q;
    end
  end

  // Stage 6: aspect multiply and numerator alignment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o <= '0;
    end else if (adv_i) begin
      out_o.valid <= vld_q[4];
      out_o.num_x <= {magr5_q, 28'd0};
      out_o.den_x <= ppv_pkg::DENX_W'(deny5_q) * ppv_pkg::DENX_W'(cfg_i.aspect);
      out_o.num_y <= {magu5_q, 20'd0};
      out_o.den_y <= deny5_q;
      out_o.num_d <= {numd5_q, 12'd0};
      out_o.den_d <= dend5_q;
      out_o.side  <= '{neg_x: negr5_q, neg_y: negu5_q, clamped: clamp5_q,
                       cfg_err: err_q[4]};
    end
  end

endmodule

`default_nettype wire

[rtl/perspective_vertex_projection.sv]
// ----------------------------------------------------------------------------
// perspective_vertex_projection
// Projects world-space vertices through a camera basis to Q4.12 NDC.
// ----------------------------------------------------------------------------
// Takes one vertex per clock while no result is held at the output, and returns
// one result per vertex, in order. Each vertex passes six front-end stages
// (eye subtract, axis products, dot sums, near clamp, two multiply stages),
// eighteen stages of the bit-per-stage dividers, and the output register.
// The whole pipeline holds while a result waits at the output.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module perspective_vertex_projection (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ppv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ppv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ppv_vtx_if.sink                               vtx_i,
  ppv_res_if.source                             res_o
);

  localparam int unsigned LAT = ppv_pkg::DIV_LAT;
  localparam int unsigned QW  = ppv_pkg::QUO_W;

  ppv_pkg::cfg_t   cfg_q;
  ppv_pkg::front_t front;
  ppv_pkg::side_t  side_q [LAT];
  logic [LAT-1:0]  vld_q;
  logic            out_vld_q;
  ppv_pkg::res_t   out_q, out_d;
  logic            adv;

  logic [QW-1:0] quo_x, quo_y, quo_d;
  logic          ovf_x, ovf_y, ovf_d;
  ppv_pkg::sat_t sx, sy, sd;

  // Pipeline advances unless a result is held at the output
  assign adv         = !out_vld_q || res_o.ready;
  assign vtx_i.ready = adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye     <= ppv_pkg::EYE_RST;
      cfg_q.right   <= ppv_pkg::RIGHT_RST;
      cfg_q.up      <= ppv_pkg::UP_RST;
      cfg_q.fwd     <= ppv_pkg::FWD_RST;
      cfg_q.tan_fov <= ppv_pkg::TAN_RST;
      cfg_q.aspect  <= ppv_pkg::ASP_RST;
      cfg_q.near    <= ppv_pkg::NEAR_RST;
      cfg_q.far     <= ppv_pkg::FAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppv_pkg::REG_EYE:   cfg_q.eye     <= cfg_data_i;
        ppv_pkg::REG_RIGHT: cfg_q.right   <= cfg_data_i;
        ppv_pkg::REG_UP:    cfg_q.up      <= cfg_data_i;
        ppv_pkg::REG_FWD:   cfg_q.fwd     <= cfg_data_i;
        ppv_pkg::REG_TAN:   cfg_q.tan_fov <= cfg_data_i[ppv_pkg::SCALAR_W-1:0];
        ppv_pkg::REG_ASP:   cfg_q.aspect  <= cfg_data_i[ppv_pkg::SCALAR_W-1:0];
        ppv_pkg::REG_NEAR:  cfg_q.near    <= cfg_data_i[ppv_pkg::SCALAR_W-1:0];
        ppv_pkg::REG_FAR:   cfg_q.far     <= cfg_data_i[ppv_pkg::SCALAR_W-1:0];
        default: ;
      endcase
    end
  end

  // View transform front end
  ppv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (vtx_i.valid),
    .in_data_i  (vtx_i.data),
    .cfg_i      (cfg_q),
    .out_o      (front)
  );

  // Divider bank
  ppv_div #(.NW(ppv_pkg::NUMX_W), .DW(ppv_pkg::DENX_W), .QW(QW)) u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (front.num_x), .den_i (front.den_x),
    .quo_o (quo_x), .ovf_o (ovf_x)
  );

  ppv_div #(.NW(ppv_pkg::NUMY_W), .DW(ppv_pkg::DENY_W), .QW(QW)) u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (front.num_y), .den_i (front.den_y),
    .quo_o (quo_y), .ovf_o (ovf_y)
  );

  ppv_div #(.NW(ppv_pkg::NUMD_W), .DW(ppv_pkg::DEND_W), .QW(QW)) u_div_d (
    .clk_i (clk_i), .en_i (adv), .num_i (front.num_d), .den_i (front.den_d),
    .quo_o (quo_d), .ovf_o (ovf_d)
  );

  // Side flags and valid bits alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], front.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= front.side;
      for (int unsigned i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Saturation and result assembly
  always_comb begin
    sx = ppv_pkg::sat16(side_q[LAT-1].neg_x, ovf_x, quo_x);
    sy = ppv_pkg::sat16(side_q[LAT-1].neg_y, ovf_y, quo_y);
    sd = ppv_pkg::sat16(1'b0, ovf_d, quo_d);
    if (side_q[LAT-1].cfg_err) begin
      out_d              = '0;
      out_d.config_error = 1'b1;
    end else begin
      out_d.ndc_x         = $signed(sx.code);
      out_d.ndc_y         = $signed(sy.code);
      out_d.ndc_depth     = $signed(sd.code);
      out_d.depth_clamped = side_q[LAT-1].clamped;
      out_d.saturated     = sx.sat | sy.sat | sd.sat;
      out_d.config_error  = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  // An unusable configuration gives an all-zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.config_error |->
      res_o.data.ndc_x == '0 && res_o.data.ndc_y == '0 &&
      res_o.data.ndc_depth == '0 && !res_o.data.saturated &&
      !res_o.data.depth_clamped)
    else $error("config error result not zero");

  // Mapped depth is never negative
  a_depth_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.data.config_error |-> !res_o.data.ndc_depth[ppv_pkg::OUT_W-1])
    else $error("negative depth");

  // A stall freezes the divider pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q) && $stable(out_vld_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
